FILE: design/dsa_pkg.sv
// Shared constants, codes and types of the descriptor slot allocator.
// No dependencies; used by dsa_ctrl and descriptor_slot_allocator.
`default_nettype none
package dsa_pkg;

  localparam int MAX_SLOTS  = 1024;
  localparam int NUM_HEAPS  = 4;
  localparam int MAX_RANGES = 16;

  localparam int SLOT_W  = 10;                          // slot offset width
  localparam int CNT_W   = 11;                          // slot count width
  localparam int HEAP_W  = 2;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int RIDX_W  = $clog2(MAX_RANGES);          // range entry index
  localparam int RCNT_W  = $clog2(MAX_RANGES + 2);      // holds up to MAX_RANGES + 1
  localparam int STK_AW  = HEAP_W + SLOT_W;
  localparam int RNG_AW  = HEAP_W + 1 + RIDX_W;         // heap, bank, index
  localparam int STK_DEPTH = NUM_HEAPS * MAX_SLOTS;
  localparam int RNG_DEPTH = NUM_HEAPS * 2 * MAX_RANGES;

  localparam logic [OP_W-1:0] OP_ALLOC_ONE   = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC_RANGE = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE_ONE    = 2'd2;
  localparam logic [OP_W-1:0] OP_FREE_RANGE  = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_IGNORED  = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0] start;
    logic [CNT_W-1:0]  len;
  } rng_entry_t;

  localparam int RNG_DW = $bits(rng_entry_t);

  typedef struct packed {
    logic              we;
    logic [STK_AW-1:0] addr;
    logic [SLOT_W-1:0] data;
  } stk_wr_t;

  typedef struct packed {
    logic              we;
    logic [RNG_AW-1:0] addr;
    rng_entry_t        data;
  } rng_wr_t;

  typedef logic [NUM_HEAPS-1:0][CNT_W-1:0] cap_arr_t;

endpackage
`default_nettype wire

FILE: design/dsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module dsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/dsa_ctrl.sv
// Request sequencer: per-heap counters, stack pop/push and range table walks.
// Depends on dsa_pkg; drives the stack and range RAMs in the top level.
`default_nettype none
module dsa_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [dsa_pkg::OP_W-1:0]   in_operation,
  input  wire logic [dsa_pkg::HEAP_W-1:0] in_heap,
  input  wire logic [dsa_pkg::SLOT_W-1:0] in_slot_offset,
  input  wire logic [dsa_pkg::CNT_W-1:0]  in_slot_count,
  input  wire logic                     in_handle_valid,
  input  wire dsa_pkg::cap_arr_t        cap,
  output logic                          out_valid,
  output logic [dsa_pkg::SLOT_W-1:0]    out_granted_offset,
  output logic [dsa_pkg::STAT_W-1:0]    out_status,
  output dsa_pkg::stk_wr_t              stk_wr,
  output logic [dsa_pkg::STK_AW-1:0]    stk_raddr,
  input  wire logic [dsa_pkg::SLOT_W-1:0] stk_rdata,
  output dsa_pkg::rng_wr_t              rng_wr,
  output logic [dsa_pkg::RNG_AW-1:0]    rng_raddr,
  input  wire dsa_pkg::rng_entry_t      rng_rdata
);
  import dsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_POP, S_TAKE, S_AR_RD, S_AR_CMP, S_FR_RD, S_FR_CMP, S_FR_TAIL, S_FR_FLUSH
  } state_t;

  state_t              state_r, state_nxt;
  logic [HEAP_W-1:0]   heap_r, heap_nxt;
  logic [SLOT_W-1:0]   off_r, off_nxt;
  logic [CNT_W-1:0]    len_r, len_nxt;
  logic [CNT_W-1:0]    sdepth_r [NUM_HEAPS];
  logic [CNT_W-1:0]    sdepth_nxt [NUM_HEAPS];
  logic [RCNT_W-1:0]   rcount_r [NUM_HEAPS];
  logic [RCNT_W-1:0]   rcount_nxt [NUM_HEAPS];
  logic [CNT_W-1:0]    bump_r [NUM_HEAPS];
  logic [CNT_W-1:0]    bump_nxt [NUM_HEAPS];
  logic [NUM_HEAPS-1:0] bank_r, bank_nxt;
  logic [RCNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [RCNT_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic                placed_r, placed_nxt;
  logic                found_r, found_nxt;
  logic                have_r, have_nxt;
  logic [SLOT_W-1:0]   last_s_r, last_s_nxt;
  logic [CNT_W-1:0]    last_e_r, last_e_nxt;
  logic [SLOT_W-1:0]   granted_r, granted_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]   out_off_r, out_off_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;

  logic                idle;
  logic [HEAP_W-1:0]   hsel;
  logic [CNT_W-1:0]    cap_eff;
  logic [CNT_W-1:0]    len_sel;
  logic [CNT_W:0]      bump_sum;
  logic                push_en;
  logic [SLOT_W-1:0]   push_s;
  logic [CNT_W-1:0]    push_l;
  logic [CNT_W-1:0]    push_e;
  logic                emit_en;
  logic [CNT_W-1:0]    new_len;
  logic [CNT_W-1:0]    avail;
  logic [RCNT_W-1:0]   fin_count;

  assign idle      = (state_r == S_IDLE);
  assign busy      = !idle;
  assign hsel      = idle ? in_heap : heap_r;
  assign cap_eff   = (cap[hsel] > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : cap[hsel];
  assign len_sel   = idle ? in_slot_count : len_r;
  assign bump_sum  = {1'b0, bump_r[hsel]} + {1'b0, len_sel};
  assign new_len   = rng_rdata.len - len_r;
  assign avail     = CNT_W'(MAX_SLOTS) - {1'b0, in_slot_offset};
  assign fin_count = wr_idx_r + RCNT_W'(1);
  assign push_e    = {1'b0, push_s} + push_l;

  assign out_valid          = out_valid_r;
  assign out_granted_offset = out_off_r;
  assign out_status         = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    heap_nxt       = heap_r;
    off_nxt        = off_r;
    len_nxt        = len_r;
    sdepth_nxt     = sdepth_r;
    rcount_nxt     = rcount_r;
    bump_nxt       = bump_r;
    bank_nxt       = bank_r;
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    placed_nxt     = placed_r;
    found_nxt      = found_r;
    have_nxt       = have_r;
    last_s_nxt     = last_s_r;
    last_e_nxt     = last_e_r;
    granted_nxt    = granted_r;
    out_valid_nxt  = 1'b0;
    out_off_nxt    = '0;
    out_status_nxt = ST_DONE;
    stk_wr         = '0;
    rng_wr         = '0;
    stk_raddr      = {heap_r, sdepth_r[heap_r][SLOT_W-1:0]};
    rng_raddr      = {heap_r, bank_r[heap_r], rd_idx_r[RIDX_W-1:0]};
    push_en        = 1'b0;
    push_s         = off_r;
    push_l         = len_r;
    emit_en        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        stk_raddr = {in_heap, SLOT_W'(sdepth_r[in_heap] - CNT_W'(1))};
        rng_raddr = {in_heap, bank_r[in_heap],
                     RIDX_W'(rcount_r[in_heap] - RCNT_W'(1))};
        if (start) begin
          heap_nxt    = in_heap;
          off_nxt     = in_slot_offset;
          len_nxt     = in_slot_count;
          rd_idx_nxt  = '0;
          wr_idx_nxt  = '0;
          placed_nxt  = 1'b0;
          found_nxt   = 1'b0;
          have_nxt    = 1'b0;
          unique case (in_operation)
            OP_ALLOC_ONE: begin
              if (sdepth_r[in_heap] != '0) begin
                sdepth_nxt[in_heap] = sdepth_r[in_heap] - CNT_W'(1);
                state_nxt = S_POP;
              end else if (rcount_r[in_heap] != '0) begin
                rd_idx_nxt = rcount_r[in_heap] - RCNT_W'(1);
                state_nxt  = S_TAKE;
              end else if (bump_r[in_heap] < cap_eff) begin
                bump_nxt[in_heap] = bump_r[in_heap] + CNT_W'(1);
                out_valid_nxt = 1'b1;
                out_off_nxt   = bump_r[in_heap][SLOT_W-1:0];
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FULL;
              end
            end
            OP_ALLOC_RANGE: begin
              if (in_slot_count == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_IGNORED;
              end else begin
                state_nxt = S_AR_RD;
              end
            end
            OP_FREE_ONE: begin
              out_valid_nxt = 1'b1;
              if (!in_handle_valid) begin
                out_status_nxt = ST_IGNORED;
              end else if (sdepth_r[in_heap] >= CNT_W'(MAX_SLOTS)) begin
                out_status_nxt = ST_OVERFLOW;
              end else begin
                stk_wr.we   = 1'b1;
                stk_wr.addr = {in_heap, sdepth_r[in_heap][SLOT_W-1:0]};
                stk_wr.data = in_slot_offset;
                sdepth_nxt[in_heap] = sdepth_r[in_heap] + CNT_W'(1);
              end
            end
            OP_FREE_RANGE: begin
              if (!in_handle_valid || in_slot_count == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_IGNORED;
              end else begin
                len_nxt   = (in_slot_count > avail) ? avail : in_slot_count;
                state_nxt = S_FR_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_POP: begin
        out_valid_nxt = 1'b1;
        out_off_nxt   = stk_rdata;
        state_nxt     = S_IDLE;
      end

      S_TAKE: begin
        // Trim one slot off the low end of the top range, in place.
        rng_wr.we         = 1'b1;
        rng_wr.addr       = {heap_r, bank_r[heap_r], rd_idx_r[RIDX_W-1:0]};
        rng_wr.data.start = rng_rdata.start + SLOT_W'(1);
        rng_wr.data.len   = rng_rdata.len - CNT_W'(1);
        if (rng_rdata.len == CNT_W'(1)) begin
          rcount_nxt[heap_r] = rcount_r[heap_r] - RCNT_W'(1);
        end
        out_valid_nxt = 1'b1;
        out_off_nxt   = rng_rdata.start;
        state_nxt     = S_IDLE;
      end

      S_AR_RD: begin
        if (rd_idx_r == rcount_r[heap_r]) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (found_r) begin
            bank_nxt[heap_r]   = ~bank_r[heap_r];
            rcount_nxt[heap_r] = wr_idx_r;
            out_off_nxt        = granted_r;
          end else if (bump_sum > {1'b0, cap_eff}) begin
            out_status_nxt = ST_FULL;
          end else begin
            bump_nxt[heap_r] = bump_sum[CNT_W-1:0];
            out_off_nxt      = bump_r[heap_r][SLOT_W-1:0];
          end
        end else begin
          state_nxt = S_AR_CMP;
        end
      end

      S_AR_CMP: begin
        // Copy into the spare bank, carving the first fitting range.
        rng_wr.addr = {heap_r, ~bank_r[heap_r], wr_idx_r[RIDX_W-1:0]};
        rng_wr.data = rng_rdata;
        if (!found_r && rng_rdata.len >= len_r) begin
          found_nxt         = 1'b1;
          granted_nxt       = rng_rdata.start;
          rng_wr.data.start = SLOT_W'({1'b0, rng_rdata.start} + len_r);
          rng_wr.data.len   = new_len;
          if (new_len != '0) begin
            rng_wr.we  = 1'b1;
            wr_idx_nxt = wr_idx_r + RCNT_W'(1);
          end
        end else begin
          rng_wr.we  = 1'b1;
          wr_idx_nxt = wr_idx_r + RCNT_W'(1);
        end
        rd_idx_nxt = rd_idx_r + RCNT_W'(1);
        state_nxt  = S_AR_RD;
      end

      S_FR_RD: begin
        state_nxt = (rd_idx_r == rcount_r[heap_r]) ? S_FR_TAIL : S_FR_CMP;
      end

      S_FR_CMP: begin
        if (!placed_r && off_r < rng_rdata.start) begin
          push_en    = 1'b1;
          placed_nxt = 1'b1;
        end else begin
          push_en    = 1'b1;
          push_s     = rng_rdata.start;
          push_l     = rng_rdata.len;
          rd_idx_nxt = rd_idx_r + RCNT_W'(1);
          state_nxt  = S_FR_RD;
        end
      end

      S_FR_TAIL: begin
        push_en    = !placed_r;
        placed_nxt = 1'b1;
        state_nxt  = S_FR_FLUSH;
      end

      S_FR_FLUSH: begin
        emit_en       = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (fin_count > RCNT_W'(MAX_RANGES)) begin
          out_status_nxt = ST_OVERFLOW;
        end else begin
          bank_nxt[heap_r]   = ~bank_r[heap_r];
          rcount_nxt[heap_r] = fin_count;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Coalescing merge: extend the pending range or retire it.
    if (push_en) begin
      if (have_r && {1'b0, push_s} <= last_e_r) begin
        if (push_e > last_e_r) begin
          last_e_nxt = push_e;
        end
      end else begin
        emit_en    = have_r;
        last_s_nxt = push_s;
        last_e_nxt = push_e;
        have_nxt   = 1'b1;
      end
    end

    if (emit_en) begin
      rng_wr.we         = (wr_idx_r < RCNT_W'(MAX_RANGES));
      rng_wr.addr       = {heap_r, ~bank_r[heap_r], wr_idx_r[RIDX_W-1:0]};
      rng_wr.data.start = last_s_r;
      rng_wr.data.len   = last_e_r - {1'b0, last_s_r};
      wr_idx_nxt        = wr_idx_r + RCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bank_r      <= '0;
      for (int i = 0; i < NUM_HEAPS; i++) begin
        sdepth_r[i] <= '0;
        rcount_r[i] <= '0;
        bump_r[i]   <= (i == 0) ? CNT_W'(1) : '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bank_r      <= bank_nxt;
      sdepth_r    <= sdepth_nxt;
      rcount_r    <= rcount_nxt;
      bump_r      <= bump_nxt;
    end
    heap_r       <= heap_nxt;
    off_r        <= off_nxt;
    len_r        <= len_nxt;
    rd_idx_r     <= rd_idx_nxt;
    wr_idx_r     <= wr_idx_nxt;
    placed_r     <= placed_nxt;
    found_r      <= found_nxt;
    have_r       <= have_nxt;
    last_s_r     <= last_s_nxt;
    last_e_r     <= last_e_nxt;
    granted_r    <= granted_nxt;
    out_off_r    <= out_off_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
`default_nettype wire

FILE: design/descriptor_slot_allocator.sv
// Descriptor slot allocator, four heaps. Single-slot frees, bump allocations and rejects
// complete straight from idle; a single-slot allocation served from stack or range table
// first reads its RAM; range operations walk the live ranges (up to 16) one at a time through
// the one read port of the range RAM, and a range free then ends with a tail and a flush step.
// One request at a time; busy high meanwhile. Results come as a one-cycle
// out_valid strobe. Synchronous active-low reset empties all stacks and range tables,
// sets capacities to 1024 and heap 0's pointer to 1. Depends on dsa_pkg, dsa_ram, dsa_ctrl.
`default_nettype none
module descriptor_slot_allocator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [dsa_pkg::OP_W-1:0]   in_operation,
  input  wire logic [dsa_pkg::HEAP_W-1:0] in_heap,
  input  wire logic [dsa_pkg::SLOT_W-1:0] in_slot_offset,
  input  wire logic [dsa_pkg::CNT_W-1:0]  in_slot_count,
  input  wire logic                       in_handle_valid,
  output logic                            out_valid,
  output logic [dsa_pkg::SLOT_W-1:0]      out_granted_offset,
  output logic [dsa_pkg::STAT_W-1:0]      out_status,
  input  wire logic                       cfg_we,
  input  wire logic [dsa_pkg::HEAP_W-1:0] cfg_index,
  input  wire logic [dsa_pkg::CNT_W-1:0]  cfg_data
);
  import dsa_pkg::*;

  // Capacity registers, one per heap; clamped to MAX_SLOTS in the sequencer.
  cap_arr_t cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_HEAPS; i++) begin
        cap_r[i] <= CNT_W'(MAX_SLOTS);
      end
    end else if (cfg_we) begin
      cap_r[cfg_index] <= cfg_data;
    end
  end

  // Stack RAM holds each heap's freed single slots, addressed {heap, depth}.
  // Range RAM holds two banks per heap; range walks copy into the spare bank
  // and flip it on success, so a dropped free leaves the live table intact.
  stk_wr_t             stk_wr;
  logic [STK_AW-1:0]   stk_raddr;
  logic [SLOT_W-1:0]   stk_rdata;
  rng_wr_t             rng_wr;
  logic [RNG_AW-1:0]   rng_raddr;
  rng_entry_t          rng_rdata;

  dsa_ram #(.WIDTH(SLOT_W), .DEPTH(STK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_wr.we),
    .waddr (stk_wr.addr),
    .wdata (stk_wr.data),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  dsa_ram #(.WIDTH(RNG_DW), .DEPTH(RNG_DEPTH)) u_range_ram (
    .clk   (clk),
    .we    (rng_wr.we),
    .waddr (rng_wr.addr),
    .wdata (rng_wr.data),
    .raddr (rng_raddr),
    .rdata (rng_rdata)
  );

  // Sequencer: decode each transfer, walk the tables, issue the result strobe.
  dsa_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_heap            (in_heap),
    .in_slot_offset     (in_slot_offset),
    .in_slot_count      (in_slot_count),
    .in_handle_valid    (in_handle_valid),
    .cap                (cap_r),
    .out_valid          (out_valid),
    .out_granted_offset (out_granted_offset),
    .out_status         (out_status),
    .stk_wr             (stk_wr),
    .stk_raddr          (stk_raddr),
    .stk_rdata          (stk_rdata),
    .rng_wr             (rng_wr),
    .rng_raddr          (rng_raddr),
    .rng_rdata          (rng_rdata)
  );

`ifndef SYNTH
  // A result is only ever issued once the sequencer is back at rest.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // An accepted transfer either completes at once or holds the sequencer.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request neither busy nor completed");

  // Every walk ends with exactly one result.
  a_walk_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("walk finished without a result");
`endif

endmodule
`default_nettype wire
